// ===== hdl/osm_pkg.sv =====
// shared types and constants of the offset to segment mapper
// no dependencies; imported by every module of the block
package osm_pkg;

   // command codes on the request sideband
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // request and response bus widths
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 64;

   // working length width: the span can grow by a full 32-bit gap per inverted region
   localparam int LEN_W = 40;

   // command queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   // classified operation kinds
   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_QUERY
   } op_kind_type;

   // one classified word as it travels through the queue
   typedef struct packed {
      op_kind_type  kind;
      logic [31:0]  region_start;
      logic [31:0]  region_end;
      logic [31:0]  rel_offset;
      logic [15:0]  span_length;
      logic         minus_strand;
   } op_type;

   // back end sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_ERR  = 4'b1000
   } state_type;

endpackage

// ===== hdl/osm_front.sv =====
// front end: accepts request words and classifies them into queue entries
// depends on osm_pkg
module osm_front
   import osm_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  q_full,
   output logic                  push_valid,
   output op_type                push_op
);

   logic known;

   // decode the command into an operation kind and unpack the payload;
   // unused codes are dropped
   always_comb begin
      push_op.kind         = OP_CLEAR;
      push_op.region_start = req_tdata[31:0];
      push_op.region_end   = req_tdata[63:32];
      push_op.rel_offset   = req_tdata[95:64];
      push_op.span_length  = req_tdata[111:96];
      push_op.minus_strand = req_tdata[112];
      known                = 1'b1;
      case (req_tuser)
         CMD_CLEAR: begin
            push_op.kind = OP_CLEAR;
         end
         CMD_APPEND: begin
            push_op.kind = OP_APPEND;
         end
         CMD_QUERY: begin
            push_op.kind = OP_QUERY;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // handshake with the queue
   assign req_tready = ~q_full;
   assign push_valid = req_tvalid & ~q_full & known;

endmodule

// ===== hdl/osm_queue.sv =====
// short queue of classified words between front and back end
// depends on osm_pkg
module osm_queue
   import osm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   input  op_type push_op,
   output logic   q_full,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type             entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign q_full    = (fill_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~q_full;
   assign do_pop    = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== hdl/osm_back.sv =====
// back end: region table, walk sequencer and response register
// depends on osm_pkg
module osm_back
   import osm_pkg::*;
#(
   parameter int MAX_REGIONS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  op_type                pop_op,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic [0:0]            rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

   // region table
   logic [31:0] start_mem [MAX_REGIONS];
   logic [31:0] end_mem   [MAX_REGIONS];
   logic [31:0] rd_s_ff, rd_e_ff;

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              out_valid_ff, out_valid_in;

   // walk state
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [31:0]       rem_ff, rem_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [31:0]       pos_ff, pos_in;
   logic              span_ph_ff, span_ph_in;
   logic              emit_ff, emit_in;
   logic              fresh_ff, fresh_in;
   logic              minus_ff, minus_in;
   logic [31:0]       qoff_ff, qoff_in;
   logic [15:0]       qspan_ff, qspan_in;

   // response payload
   logic [31:0]       out_start_ff, out_start_in;
   logic [31:0]       out_end_ff, out_end_in;
   logic              out_last_ff, out_last_in;
   logic              out_err_ff, out_err_in;
   logic              load;

   // helpers
   logic              out_free;
   logic              do_append;
   logic [CNT_W-1:0]  last_idx;
   logic [IDX_W-1:0]  k_first, k_step;
   logic              at_edge;
   logic [31:0]       seg_len;
   logic [31:0]       pos_eff;
   logic [LEN_W-1:0]  pl, sl, new_len;
   logic              over;

   assign out_free  = ~out_valid_ff | rsp_tready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign do_append = pop_ready & pop_valid & (pop_op.kind == OP_APPEND) &
                      (count_ff != MAX_CNT);

   // walk direction and table edge
   assign last_idx = count_ff - 1'b1;
   assign k_first  = pop_op.minus_strand ? last_idx[IDX_W-1:0] : '0;
   assign k_step   = minus_ff ? k_ff - 1'b1 : k_ff + 1'b1;
   assign at_edge  = minus_ff ? (k_ff == '0) : (CNT_W'(k_ff) == last_idx);

   // region length, inverted regions count as zero
   assign seg_len = (rd_e_ff >= rd_s_ff) ? rd_e_ff - rd_s_ff : '0;

   // span arithmetic for the current region
   assign pos_eff = fresh_ff ? (minus_ff ? rd_e_ff : rd_s_ff) : pos_ff;
   assign pl      = LEN_W'(pos_eff) + len_ff;
   assign sl      = LEN_W'(rd_s_ff) + len_ff;
   always_comb begin
      if (minus_ff) begin
         over    = LEN_W'(pos_eff) < sl;
         new_len = sl - LEN_W'(pos_eff);
      end else begin
         over    = pl > LEN_W'(rd_e_ff);
         new_len = pl - LEN_W'(rd_e_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      span_ph_in   = span_ph_ff;
      emit_in      = emit_ff;
      fresh_in     = fresh_ff;
      minus_in     = minus_ff;
      qoff_in      = qoff_ff;
      qspan_in     = qspan_ff;
      load         = 1'b0;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_op.kind)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (do_append) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     minus_in   = pop_op.minus_strand;
                     qoff_in    = pop_op.rel_offset;
                     qspan_in   = pop_op.span_length;
                     rem_in     = pop_op.rel_offset;
                     len_in     = LEN_W'(pop_op.span_length);
                     k_in       = k_first;
                     span_ph_in = 1'b0;
                     fresh_in   = 1'b0;
                     emit_in    = 1'b0;
                     state_in   = (count_ff == '0) ? ST_ERR : ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!span_ph_ff) begin
               // skip whole regions until the offset fits
               if (rem_ff > seg_len) begin
                  rem_in = rem_ff - seg_len;
                  if (at_edge) begin
                     state_in = ST_ERR;
                  end else begin
                     k_in     = k_step;
                     state_in = ST_READ;
                  end
               end else begin
                  pos_in     = minus_ff ? rd_e_ff - rem_ff : rd_s_ff + rem_ff;
                  fresh_in   = 1'b0;
                  span_ph_in = 1'b1;
               end
            end else if (over) begin
               // segment closes at the region boundary
               if (!emit_ff || out_free) begin
                  if (emit_ff) begin
                     load         = 1'b1;
                     out_start_in = minus_ff ? rd_s_ff : pos_eff;
                     out_end_in   = minus_ff ? pos_eff : rd_e_ff;
                     out_last_in  = 1'b0;
                     out_err_in   = 1'b0;
                  end
                  len_in = new_len;
                  if (at_edge) begin
                     state_in = ST_ERR;
                  end else begin
                     k_in     = k_step;
                     fresh_in = 1'b1;
                     state_in = ST_READ;
                  end
               end
            end else if (emit_ff) begin
               // final segment of the query
               if (out_free) begin
                  load         = 1'b1;
                  out_start_in = minus_ff ? pos_eff - len_ff[31:0] : pos_eff;
                  out_end_in   = minus_ff ? pos_eff : pl[31:0];
                  out_last_in  = 1'b1;
                  out_err_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               // check walk fits the table: walk again and emit
               emit_in    = 1'b1;
               rem_in     = qoff_ff;
               len_in     = LEN_W'(qspan_ff);
               k_in       = minus_ff ? last_idx[IDX_W-1:0] : '0;
               span_ph_in = 1'b0;
               fresh_in   = 1'b0;
               state_in   = ST_READ;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               load         = 1'b1;
               out_start_in = '0;
               out_end_in   = '0;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = load | (out_valid_ff & ~rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      span_ph_ff   <= span_ph_in;
      emit_ff      <= emit_in;
      fresh_ff     <= fresh_in;
      minus_ff     <= minus_in;
      qoff_ff      <= qoff_in;
      qspan_ff     <= qspan_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   // table write on append, registered read while walking
   always_ff @(posedge clock) begin
      if (do_append) begin
         start_mem[count_ff[IDX_W-1:0]] <= pop_op.region_start;
         end_mem[count_ff[IDX_W-1:0]]   <= pop_op.region_end;
      end
      if (state_ff == ST_READ) begin
         rd_s_ff <= start_mem[k_ff];
         rd_e_ff <= end_mem[k_ff];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_end_ff, out_start_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

// ===== hdl/offset_to_segment_mapper_unit.sv =====
// top level of the offset to segment mapper: front end, queue and back end
// depends on osm_pkg, osm_front, osm_queue and osm_back
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata fields, tuser command
//   rsp      out        rsp_tvalid/rsp_tready  tdata segment, tlast, tuser error
//
// clear and append words are handled in the idle state of the back end as they leave the queue.
// a query walks the table twice, a check walk then an emitting walk, through one
// table read port: every region visited passes through a read state and an evaluate
// state, and each walk enters the span in an evaluate step of its own.
// reset is synchronous and empties the table and the queue; the table contents stay.
// the queue keeps taking words, until it is full, while the back end walks or waits on rsp_tready.
module offset_to_segment_mapper_unit
   import osm_pkg::*;
#(
   parameter int MAX_REGIONS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // region_start [31:0], region_end [63:32], rel_offset [95:64],
   // span_length [111:96], minus_strand [112], zero fill [119:113]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command [1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // seg_start [31:0], seg_end [63:32]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // out_of_range [0]
   output logic [0:0]            rsp_tuser
);

   logic   q_full;
   logic   push_valid;
   op_type push_op;
   logic   pop_valid;
   logic   pop_ready;
   op_type pop_op;

   // accept and classify
   osm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   // decoupling queue
   osm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .q_full     (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // table and walk
   osm_back #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/osm_segment_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the offset to segment mapper: watches the request and response streams,
// keeps its own region table, predicts the segments of each query and checks every word
// depends on osm_pkg for the command codes and bus widths
module osm_segment_checker
   import osm_pkg::*;
#(
   parameter int MAX_REGIONS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // region_start [31:0], region_end [63:32], rel_offset [95:64],
   // span_length [111:96], minus_strand [112], zero fill [119:113]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command [1:0]
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // seg_start [31:0], seg_end [63:32]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   // out_of_range [0]
   input  logic [0:0]            rsp_tuser,
   output int                    failure_count,
   output int                    pending_segments,
   output int                    segments_checked,
   output int                    overrun_results
);

   typedef struct packed {
      logic [31:0] seg_start;
      logic [31:0] seg_end;
      logic        last_seg;
      logic        out_of_range;
   } segment_type;

   segment_type expected_segments[$];
   logic [31:0] stored_starts [MAX_REGIONS];
   logic [31:0] stored_ends   [MAX_REGIONS];
   int          stored_count;

   initial begin
      failure_count    = 0;
      pending_segments = 0;
      segments_checked = 0;
      overrun_results  = 0;
      stored_count     = 0;
   end

   // length used when skipping; an inverted region counts as empty
   function automatic longint region_span(input int idx);
      longint s;
      longint e;
      s = longint'(stored_starts[idx]);
      e = longint'(stored_ends[idx]);
      return (e >= s) ? e - s : 0;
   endfunction

   function automatic segment_type make_segment(input longint s, input longint e,
                                                input logic last, input logic oor);
      segment_type seg;
      seg.seg_start    = s[31:0];
      seg.seg_end      = e[31:0];
      seg.last_seg     = last;
      seg.out_of_range = oor;
      return seg;
   endfunction

   // walk the stored regions and queue the segments one query should give
   task automatic predict_query(input longint remaining, input longint left,
                                input logic minus);
      segment_type found[$];
      longint      pos;
      int          k;
      bit          overrun;
      overrun = (stored_count == 0);
      if (!minus) begin
         // plus strand: skip forward, then lay the span from pos upward
         k = 0;
         while (!overrun && remaining > region_span(k)) begin
            remaining -= region_span(k);
            k++;
            if (k >= stored_count) overrun = 1;
         end
         if (!overrun) pos = longint'(stored_starts[k]) + remaining;
         while (!overrun && pos + left > longint'(stored_ends[k])) begin
            left = pos + left - longint'(stored_ends[k]);
            found = {found, make_segment(pos, stored_ends[k], 1'b0, 1'b0)};
            k++;
            if (k >= stored_count) overrun = 1;
            else pos = longint'(stored_starts[k]);
         end
         if (!overrun) found = {found, make_segment(pos, pos + left, 1'b1, 1'b0)};
      end else begin
         // minus strand: skip backward from the last region, pos is the segment end
         k = stored_count - 1;
         while (!overrun && remaining > region_span(k)) begin
            remaining -= region_span(k);
            k--;
            if (k < 0) overrun = 1;
         end
         if (!overrun) pos = longint'(stored_ends[k]) - remaining;
         while (!overrun && pos - left < longint'(stored_starts[k])) begin
            left = longint'(stored_starts[k]) - (pos - left);
            found = {found, make_segment(stored_starts[k], pos, 1'b0, 1'b0)};
            k--;
            if (k < 0) overrun = 1;
            else pos = longint'(stored_ends[k]);
         end
         if (!overrun) found = {found, make_segment(pos - left, pos, 1'b1, 1'b0)};
      end
      // running past the table drops whatever was found so far
      if (overrun) expected_segments = {expected_segments, make_segment(0, 0, 1'b1, 1'b1)};
      else expected_segments = {expected_segments, found};
   endtask

   task automatic report_failure(input string what, input segment_type want,
                                 input segment_type got);
      failure_count++;
      if (failure_count <= 10)
         $display("%0t mismatch, %s: expected %h..%h last %b oor %b, got %h..%h last %b oor %b",
                  $time, what, want.seg_start, want.seg_end, want.last_seg,
                  want.out_of_range, got.seg_start, got.seg_end, got.last_seg,
                  got.out_of_range);
   endtask

   // compare one response word with the oldest expected segment
   task automatic check_response();
      segment_type got;
      segment_type want;
      got.seg_start    = rsp_tdata[31:0];
      got.seg_end      = rsp_tdata[63:32];
      got.last_seg     = rsp_tlast;
      got.out_of_range = rsp_tuser[0];
      segments_checked++;
      if (got.out_of_range) overrun_results++;
      if (expected_segments.size() == 0) begin
         report_failure("no segment expected", '0, got);
      end else begin
         want = expected_segments.pop_front();
         if (got.seg_start !== want.seg_start || got.seg_end !== want.seg_end ||
             got.last_seg !== want.last_seg || got.out_of_range !== want.out_of_range)
            report_failure("field mismatch", want, got);
      end
   endtask

   // sample both streams at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         expected_segments.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_CLEAR: begin
                  stored_count = 0;
               end
               CMD_APPEND: begin
                  if (stored_count < MAX_REGIONS) begin
                     stored_starts[stored_count] = req_tdata[31:0];
                     stored_ends[stored_count]   = req_tdata[63:32];
                     stored_count++;
                  end
               end
               CMD_QUERY: begin
                  predict_query(req_tdata[95:64], req_tdata[111:96], req_tdata[112]);
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_response();
      end
      pending_segments <= expected_segments.size();
   end

endmodule

// ===== dv/offset_to_segment_mapper_unit_tb.sv =====
`timescale 1ns / 100ps
// top of the offset to segment mapper testbench: clock, reset, request stimulus,
// response pacing and the final verdict
// depends on osm_pkg, offset_to_segment_mapper_unit and osm_segment_checker
module offset_to_segment_mapper_unit_tb;
   import osm_pkg::*;

   localparam int         CLK_HALF     = 4;
   localparam int         RESET_CYCLES = 6;
   localparam int         MAX_REGIONS  = 64;
   localparam int         ITEM_TARGET  = 320;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 300;
   localparam int         IDLE_LIMIT   = 4000;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   typedef enum {PACE_OPEN, PACE_BUSY, PACE_CHOKED} pace_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // region_start [31:0], region_end [63:32], rel_offset [95:64],
   // span_length [111:96], minus_strand [112], zero fill [119:113]
   logic [REQ_DATA_W-1:0] req_tdata;
   // command [1:0]
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // seg_start [31:0], seg_end [63:32]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   // out_of_range [0]
   logic [0:0]            rsp_tuser;

   int failure_count;
   int pending_segments;
   int segments_checked;
   int overrun_results;

   // sender bookkeeping, used to shape offsets and for the summary
   int     burst_left    = 0;
   int     items_sent    = 0;
   int     queries_sent  = 0;
   int     stored_regions = 0;
   int     largest_table = 0;
   longint mapped_total  = 0;
   bit     hold_request  = 0;
   bit     hold_active   = 0;
   bit     hold_served   = 0;

   always #CLK_HALF clock = ~clock;

   offset_to_segment_mapper_unit #(
      .MAX_REGIONS(MAX_REGIONS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   osm_segment_checker #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .rsp_tuser        (rsp_tuser),
      .failure_count    (failure_count),
      .pending_segments (pending_segments),
      .segments_checked (segments_checked),
      .overrun_results  (overrun_results)
   );

   // offer one word, with a random gap once a burst is used up
   task automatic send_word(input logic [1:0] cmd, input logic [31:0] first_pos,
                            input logic [31:0] end_pos, input logic [31:0] offset,
                            input logic [15:0] span, input logic minus);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, minus, span, offset, end_pos, first_pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
      // keep track of the table as the block should see it
      case (cmd)
         CMD_CLEAR: begin
            stored_regions = 0;
            mapped_total   = 0;
         end
         CMD_APPEND: begin
            if (stored_regions < MAX_REGIONS) begin
               stored_regions++;
               if (end_pos >= first_pos) mapped_total += end_pos - first_pos;
               if (stored_regions > largest_table) largest_table = stored_regions;
            end
         end
         CMD_QUERY: begin
            queries_sent++;
         end
         default: begin
         end
      endcase
   endtask

   task automatic clear_table();
      send_word(CMD_CLEAR, $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom));
   endtask

   task automatic append_region(input logic [31:0] first, input logic [31:0] last_pos);
      send_word(CMD_APPEND, first, last_pos, $urandom, 16'($urandom), 1'($urandom));
   endtask

   task automatic map_query(input logic [31:0] offset, input logic [15:0] span,
                            input logic minus);
      send_word(CMD_QUERY, $urandom, $urandom, offset, span, minus);
   endtask

   // fresh ascending table, with the odd empty or inverted region
   task automatic build_table(input int count, input bit wide);
      logic [31:0] cursor;
      logic [31:0] first;
      logic [31:0] last_pos;
      int          shape;
      clear_table();
      cursor = wide ? $urandom : $urandom_range(1000000, 0);
      repeat (count) begin
         first = cursor + $urandom_range(40, 0);
         shape = $urandom_range(0, 15);
         if (shape == 0) last_pos = first - $urandom_range(1, 30);
         else if (shape == 1) last_pos = first;
         else last_pos = first + $urandom_range(1, 120);
         append_region(first, last_pos);
         cursor = (shape == 0) ? first : last_pos;
      end
   endtask

   // query mostly inside the mapped length, sometimes past it or anywhere
   task automatic pick_query();
      logic [31:0] offset;
      logic [15:0] span;
      longint      reach;
      int          pick;
      reach = (mapped_total > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : mapped_total;
      pick  = $urandom_range(0, 99);
      if (pick < 78) offset = $urandom_range(32'(reach), 0);
      else if (pick < 90) offset = 32'(reach) + $urandom_range(1, 60);
      else offset = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 65) span = 16'($urandom_range(0, 60));
      else if (pick < 90) span = 16'($urandom_range(0, 500));
      else span = 16'($urandom_range(0, 65535));
      map_query(offset, span, 1'($urandom_range(0, 1)));
   endtask

   // drop valid and let one edge pass before the sender waits on something
   task automatic pause_sender();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // response side: random stall patterns, plus one long hold-off on request
   initial begin : response_pacing
      pace_type mode;
      int       stretch;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_served) begin
            hold_active = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 0;
            hold_served = 1;
         end else begin
            mode    = pace_type'($urandom_range(0, 2));
            stretch = $urandom_range(4, 60);
            repeat (stretch) begin
               case (mode)
                  PACE_OPEN:   rsp_tready <= 1'b1;
                  PACE_BUSY:   rsp_tready <= ($urandom_range(0, 9) < 7);
                  PACE_CHOKED: rsp_tready <= ($urandom_range(0, 9) < 2);
                  default:     rsp_tready <= 1'b1;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // end the run if no word moves on either stream for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: %0d cycles with no word accepted", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      int pick;
      int count;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_CLEAR;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table on both strands
      clear_table();
      map_query(32'd0, 16'd10, 1'b0);
      map_query(32'd0, 16'd10, 1'b1);
      // small table with an inverted region and one ending at the top of the range
      append_region(32'd100, 32'd150);
      append_region(32'd300, 32'd200);
      append_region(32'd400, 32'd480);
      append_region(32'hFFFF_FF00, 32'hFFFF_FFFF);
      map_query(32'd0, 16'd0, 1'b0);
      // offset equal to the first length lands on its end, zero-length segment
      map_query(32'd50, 16'd0, 1'b0);
      // span across the inverted region into the last one
      map_query(32'd40, 16'd30, 1'b0);
      map_query(32'd130, 16'd0, 1'b0);
      map_query(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      map_query(32'd0, 16'hFFFF, 1'b0);
      map_query(32'd0, 16'd0, 1'b1);
      map_query(32'd255, 16'd5, 1'b1);
      map_query(32'd300, 16'd100, 1'b1);
      map_query(32'd1000, 16'd1, 1'b1);
      // unused command is ignored
      send_word(CMD_UNUSED, $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom));
      append_region(32'hFFFF_FFFF, 32'd0);
      map_query(32'd0, 16'hFFFF, 1'b1);
      clear_table();
      map_query(32'd5, 16'd5, 1'b0);

      // long response hold-off while queries keep coming
      build_table(6, 1'b0);
      pause_sender();
      hold_request = 1;
      while (!hold_active) @(posedge clock);
      repeat (20) pick_query();

      // random sequences: build a table then query it, with some noise
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            count = $urandom_range(0, 99);
            if (count < 80) count = $urandom_range(1, 8);
            else if (count < 97) count = $urandom_range(9, 24);
            else count = MAX_REGIONS;
            build_table(count, $urandom_range(0, 3) == 0);
            // one more append on a full table is ignored
            if (count == MAX_REGIONS) append_region($urandom, $urandom);
            repeat ($urandom_range(2, 8)) pick_query();
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) pick_query();
         end else if (pick < 83) begin
            send_word(CMD_UNUSED, $urandom, $urandom, $urandom, 16'($urandom),
                      1'($urandom));
            append_region($urandom, $urandom);
         end else if (pick < 90) begin
            clear_table();
            pick_query();
         end else begin
            map_query($urandom, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
         end
      end

      // drain and give the block time to show any stray word
      req_tvalid <= 1'b0;
      while (pending_segments != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run sent %0d words, %0d of them queries, tables of up to %0d regions",
               items_sent, queries_sent, largest_table);
      $display("checked %0d segments, %0d past-table results, %0d failures",
               segments_checked, overrun_results, failure_count + pending_segments);
      if (failure_count + pending_segments == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/osm_pkg.sv
hdl/osm_front.sv
hdl/osm_queue.sv
hdl/osm_back.sv
hdl/offset_to_segment_mapper_unit.sv
dv/osm_segment_checker.sv
dv/offset_to_segment_mapper_unit_tb.sv
